>>> src/jblc_pkg.sv
// ----------------------------------------------------------------------------
// jblc_pkg
// Shared types, codes and constants of the journal block log controller.
// ----------------------------------------------------------------------------
package jblc_pkg;

  // default number of table entries
  localparam int unsigned JBLC_LOG_CAPACITY = 30;

  // configuration port
  localparam int unsigned JBLC_ADDR_W = 4;
  localparam int unsigned JBLC_DATA_W = 32;

  localparam logic [1:0] REG_LOG_START = 2'd0;
  localparam logic [1:0] REG_DEVICE    = 2'd1;
  localparam logic [1:0] REG_RESERVE   = 2'd2;

  localparam logic [4:0] RESERVE_RESET = 5'd10;

  // opcodes
  localparam logic [2:0] OP_BEGIN  = 3'd0;
  localparam logic [2:0] OP_END    = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_COPY   = 2'd1;
  localparam logic [1:0] KIND_HEADER = 2'd2;

  // reply status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_NO_BEGIN = 3'd4;

  // input word
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] block_number;
  } item_t;

  // result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  device;
    logic [31:0] source_block;
    logic [31:0] dest_block;
    logic [4:0]  header_count;
    logic        pin_block;
    logic        unpin_dest;
    logic        last;
  } result_t;

  // configuration register contents
  typedef struct packed {
    logic [31:0] log_start_block;
    logic [7:0]  disk_device;
    logic [4:0]  reserve_per_operation;
  } cfg_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CPY_RD,
    S_CPY_EMIT,
    S_HDR_CNT,
    S_INST_RD,
    S_INST_EMIT,
    S_HDR_ZERO
  } state_t;

  // result word selection in the datapath
  typedef enum logic [2:0] {
    EM_REPLY,
    EM_COPY_OUT,
    EM_HDR_CNT,
    EM_INSTALL,
    EM_HDR_ZERO
  } emit_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       mem_rd;
    logic       append;
    logic       open_inc;
    logic       open_dec;
    logic       cnt_clr;
    logic       emit;
    emit_t      emit_sel;
    logic [2:0] status;
    logic       pin;
    logic       unpin;
    logic       last;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] opcode;
    logic       begin_ok;
    logic       open_zero;
    logic       open_one;
    logic       log_full;
    logic       cnt_zero;
    logic       idx_last;
    logic       match;
  } dp_sts_t;

endpackage

>>> src/jblc_regs.sv
// ----------------------------------------------------------------------------
// jblc_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module jblc_regs import jblc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [JBLC_ADDR_W-1:0] paddr,
  input  logic [JBLC_DATA_W-1:0] pwdata,
  output logic [JBLC_DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log_start_block       <= '0;
      cfg.disk_device           <= '0;
      cfg.reserve_per_operation <= RESERVE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LOG_START: cfg.log_start_block       <= pwdata;
        REG_DEVICE:    cfg.disk_device           <= pwdata[7:0];
        REG_RESERVE:   cfg.reserve_per_operation <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      REG_LOG_START: prdata = cfg.log_start_block;
      REG_DEVICE:    prdata = {24'd0, cfg.disk_device};
      REG_RESERVE:   prdata = {27'd0, cfg.reserve_per_operation};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> src/jblc_ctrl.sv
// ----------------------------------------------------------------------------
// jblc_ctrl
// Sequencer: decodes each word, walks the table for search, commit, finish.
// ----------------------------------------------------------------------------
module jblc_ctrl import jblc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (sts.opcode)
          OP_END: begin
            if (!sts.open_zero && sts.open_one && !sts.cnt_zero) state_next = S_CPY_RD;
          end
          OP_WRITE: begin
            if (!sts.log_full && !sts.open_zero && !sts.cnt_zero) state_next = S_SRCH_RD;
          end
          OP_FINISH: begin
            state_next = sts.cnt_zero ? S_HDR_ZERO : S_INST_RD;
          end
          default: ;
        endcase
      end
      S_SRCH_RD:   state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (sts.match || sts.idx_last) state_next = S_IDLE;
        else                           state_next = S_SRCH_RD;
      end
      S_CPY_RD:    state_next = S_CPY_EMIT;
      S_CPY_EMIT:  state_next = sts.idx_last ? S_HDR_CNT : S_CPY_RD;
      S_HDR_CNT:   state_next = S_INST_RD;
      S_INST_RD:   state_next = S_INST_EMIT;
      S_INST_EMIT: state_next = sts.idx_last ? S_HDR_ZERO : S_INST_RD;
      S_HDR_ZERO:  state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.emit_sel = EM_REPLY;
    cmd.status   = ST_OK;
    cmd.unpin    = (sts.opcode == OP_END);
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        case (sts.opcode)
          OP_BEGIN: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            if (sts.begin_ok) cmd.open_inc = 1'b1;
            else              cmd.status   = ST_WAIT;
          end
          OP_END: begin
            if (sts.open_zero) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = ST_NO_BEGIN;
            end else begin
              cmd.open_dec = 1'b1;
              cmd.idx_clr  = 1'b1;
              // last operation closing a non-empty log starts a commit
              if (!(sts.open_one && !sts.cnt_zero)) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
              end
            end
          end
          OP_WRITE: begin
            cmd.idx_clr = 1'b1;
            if (sts.log_full) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = ST_FULL;
            end else if (sts.open_zero) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = ST_OUTSIDE;
            end else if (sts.cnt_zero) begin
              cmd.append = 1'b1;
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.pin    = 1'b1;
            end
          end
          OP_LOAD: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            if (sts.log_full) cmd.status = ST_FULL;
            else              cmd.append = 1'b1;
          end
          OP_FINISH: begin
            cmd.idx_clr = 1'b1;
          end
          default: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
          end
        endcase
      end
      S_SRCH_RD, S_CPY_RD, S_INST_RD: begin
        cmd.mem_rd = 1'b1;
      end
      S_SRCH_CMP: begin
        if (sts.match) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
        end else if (sts.idx_last) begin
          // no duplicate found: append and pin
          cmd.append = 1'b1;
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.pin    = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CPY_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EM_COPY_OUT;
        if (sts.idx_last) cmd.idx_clr = 1'b1;
        else              cmd.idx_inc = 1'b1;
      end
      S_HDR_CNT: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EM_HDR_CNT;
      end
      S_INST_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EM_INSTALL;
        cmd.idx_inc  = 1'b1;
      end
      S_HDR_ZERO: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EM_HDR_ZERO;
        cmd.last     = 1'b1;
        cmd.cnt_clr  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> src/jblc_dpath.sv
// ----------------------------------------------------------------------------
// jblc_dpath
// Block table, entry and operation counters, and the result register.
// ----------------------------------------------------------------------------
module jblc_dpath import jblc_pkg::*; #(
  parameter int unsigned LOG_CAPACITY = JBLC_LOG_CAPACITY
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cfg_t    cfg,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output result_t result,
  output logic    result_valid
);

  localparam int unsigned IDX_W = (LOG_CAPACITY > 1) ? $clog2(LOG_CAPACITY) : 1;
  localparam logic [4:0]  CAP   = 5'(LOG_CAPACITY);

  // block table, single port with registered read
  logic [31:0] table_mem [LOG_CAPACITY];
  logic [31:0] rd_data;

  logic [2:0]  opcode_q;
  logic [31:0] blk_q;
  logic [4:0]  entry_count;
  logic [4:0]  open_ops;
  logic [4:0]  idx;

  logic [5:0]  open_plus;
  logic [10:0] reserved;
  logic [11:0] demand;
  logic [31:0] log_addr;
  result_t     result_next;

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode_q <= item.opcode;
      blk_q    <= item.block_number;
    end
  end

  // table write and read
  always_ff @(posedge clk) begin
    if (cmd.append) table_mem[entry_count[IDX_W-1:0]] <= blk_q;
    if (cmd.mem_rd) rd_data <= table_mem[idx[IDX_W-1:0]];
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      open_ops    <= '0;
      idx         <= '0;
    end else begin
      if (cmd.cnt_clr)     entry_count <= '0;
      else if (cmd.append) entry_count <= entry_count + 5'd1;
      if (cmd.open_inc)      open_ops <= open_ops + 5'd1;
      else if (cmd.open_dec) open_ops <= open_ops - 5'd1;
      if (cmd.idx_clr)      idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 5'd1;
    end
  end

  // admission check: count + (open + 1) * reserve must fit
  assign open_plus = {1'b0, open_ops} + 6'd1;
  assign reserved  = 11'(open_plus * cfg.reserve_per_operation);
  assign demand    = {7'd0, entry_count} + {1'b0, reserved};

  always_comb begin
    sts.opcode    = opcode_q;
    sts.begin_ok  = (open_ops != 5'd31) && (demand <= {7'd0, CAP});
    sts.open_zero = (open_ops == 5'd0);
    sts.open_one  = (open_ops == 5'd1);
    sts.log_full  = (entry_count >= CAP);
    sts.cnt_zero  = (entry_count == 5'd0);
    sts.idx_last  = ((idx + 5'd1) == entry_count);
    sts.match     = (rd_data == blk_q);
  end

  // log data block for the current entry
  assign log_addr = cfg.log_start_block + 32'd1 + {27'd0, idx};

  // result word selection
  always_comb begin
    result_next      = '0;
    result_next.last = cmd.last;
    case (cmd.emit_sel)
      EM_REPLY: begin
        result_next.kind      = KIND_REPLY;
        result_next.status    = cmd.status;
        result_next.pin_block = cmd.pin;
      end
      EM_COPY_OUT: begin
        result_next.kind         = KIND_COPY;
        result_next.device       = cfg.disk_device;
        result_next.source_block = rd_data;
        result_next.dest_block   = log_addr;
      end
      EM_HDR_CNT: begin
        result_next.kind         = KIND_HEADER;
        result_next.device       = cfg.disk_device;
        result_next.dest_block   = cfg.log_start_block;
        result_next.header_count = entry_count;
      end
      EM_INSTALL: begin
        result_next.kind         = KIND_COPY;
        result_next.device       = cfg.disk_device;
        result_next.source_block = log_addr;
        result_next.dest_block   = rd_data;
        result_next.unpin_dest   = cmd.unpin;
      end
      EM_HDR_ZERO: begin
        result_next.kind       = KIND_HEADER;
        result_next.device     = cfg.disk_device;
        result_next.dest_block = cfg.log_start_block;
      end
      default: ;
    endcase
  end

  // result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) result <= result_next;
  end

endmodule

>>> src/journal_block_log_controller.sv
// ----------------------------------------------------------------------------
// journal_block_log_controller
// Write-ahead journal controller: admission, block logging, commit, recovery.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the word's last result has been issued. Each result sits on result for one
// cycle with result_valid high and cannot be held off, so the receiver must
// take it on that cycle. A word is accepted in idle, then decoded; a write
// whose block is not yet known reads and compares table entries in turn, a
// commit copies each entry to the log, writes the header count, installs
// each entry and zeroes the header, and a recovery finish installs each entry
// and zeroes the header. The table is single-port with a registered read, so
// each entry is read in one state, used in the next; results are registered.
module journal_block_log_controller import jblc_pkg::*; #(
  parameter int unsigned LOG_CAPACITY = JBLC_LOG_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output result_t                result,
  output logic                   result_valid,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [JBLC_ADDR_W-1:0] paddr,
  input  logic [JBLC_DATA_W-1:0] pwdata,
  output logic [JBLC_DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  jblc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jblc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  jblc_dpath #(
    .LOG_CAPACITY (LOG_CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
